### rtl/core/tw7s_pkg.sv
package tw7s_pkg;

	// Frame section of the two-wire transfer
	typedef enum logic [1:0] {
		PART_START = 2'd0,
		PART_BITS  = 2'd1,
		PART_ACK   = 2'd2,
		PART_STOP  = 2'd3
	} part_t;

	// Input item kinds
	localparam logic KIND_SHOW = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Frame bytes
	localparam logic [7:0] CMD_DATA   = 8'h40;
	localparam logic [7:0] CMD_ADDR   = 8'hC0;
	localparam logic [7:0] CMD_DISPON = 8'h8F;
	localparam logic [7:0] COLON_BIT  = 8'h80;

	localparam logic [1:0] FRAME_DATA   = 2'd0;
	localparam logic [1:0] FRAME_ADDR   = 2'd1;
	localparam logic [1:0] FRAME_DISPON = 2'd2;

	localparam logic [2:0] LAST_BIT   = 3'd7;
	localparam logic [2:0] LAST_DIGIT = 3'd4;

	// Segment pattern of one decimal digit; blank above nine
	function automatic logic [7:0] seg_pattern(input logic [3:0] d);
		logic [7:0] p;
		case (d)
			4'd0: p = 8'h3F;
			4'd1: p = 8'h06;
			4'd2: p = 8'h5B;
			4'd3: p = 8'h4F;
			4'd4: p = 8'h66;
			4'd5: p = 8'h6D;
			4'd6: p = 8'h7D;
			4'd7: p = 8'h07;
			4'd8: p = 8'h7F;
			4'd9: p = 8'h6F;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

	// Tens of a 7-bit value by reciprocal multiply (exact below 128)
	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [14:0] p;
		p = 15'(v) * 15'd205;
		return 4'(p >> 11);
	endfunction

	function automatic logic [3:0] units_of(input logic [6:0] v);
		logic [3:0] t;
		logic [6:0] tt;
		t  = tens_of(v);
		tt = 7'({3'b000, t}) * 7'd10;
		return 4'(v - tt);
	endfunction

endpackage

### rtl/core/two_wire_seven_segment_time_driver.sv
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata[15:0], s_tuser[0] = kind (0 show, 1 tick)
// m_*      out  m_tvalid/m_tready  m_tdata[7:0] = pin levels and busy flag
//
// One item per cycle while results are taken: a transfer lands in the input
// register, and the pin stepper then updates state and loads the result register.
// Every accepted item gives exactly one result transfer.
// Reset drives all four pins high and leaves the stepper idle.
// A stalled result holds the pipe; the input register refills the same
// cycle the result register frees up.
module two_wire_seven_segment_time_driver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] display_select, [7:1] minutes, [14:8] seconds, [15] colon
	input  logic [15:0] s_tdata,
	// [0] kind
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] clock_a, [1] data_a, [2] clock_b, [3] data_b, [4] busy_res, [7:5] zero
	output logic [7:0]  m_tdata
);

	// Input register
	logic       valid_s1;
	logic       kind_s1;
	logic       disp_s1;
	logic [6:0] min_s1;
	logic [6:0] sec_s1;
	logic       colon_s1;

	// Stepper state
	tw7s_pkg::part_t part_q, part_d;
	logic [3:0] pins_q, pins_d;
	logic       active_q, active_d;
	logic       tgt_q;
	logic [7:0] digit_q [4];
	logic [1:0] frame_q, frame_d;
	logic [2:0] byte_q, byte_d;
	logic [2:0] bit_q, bit_d;
	logic [1:0] ph_q, ph_d;
	logic [7:0] shift_q, shift_d;

	logic       adv;
	logic       tick_go;
	logic       show_go;
	logic       pin_is_data;
	logic       pin_lvl;
	logic [2:0] fb_idx;
	logic [2:0] fb_dig;
	logic [7:0] fb_byte;
	logic [7:0] dig1;

	// Advance the input register whenever the result register can take a value
	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign tick_go  = valid_s1 && (kind_s1 == tw7s_pkg::KIND_TICK) && active_q;
	assign show_go  = valid_s1 && (kind_s1 == tw7s_pkg::KIND_SHOW) && !active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1  <= s_tuser[0];
			disp_s1  <= s_tdata[0];
			min_s1   <= s_tdata[7:1];
			sec_s1   <= s_tdata[14:8];
			colon_s1 <= s_tdata[15];
		end
	end

	// Byte for the frame section being entered: the address frame walks digits
	assign fb_idx = (part_q == tw7s_pkg::PART_ACK) ? byte_q + 3'd1 : byte_q;
	assign fb_dig = fb_idx - 3'd1;

	always_comb begin
		case (frame_q)
			tw7s_pkg::FRAME_DATA: fb_byte = tw7s_pkg::CMD_DATA;
			tw7s_pkg::FRAME_ADDR: fb_byte = (fb_idx == 3'd0) ? tw7s_pkg::CMD_ADDR
			                                                 : digit_q[fb_dig[1:0]];
			default: fb_byte = tw7s_pkg::CMD_DISPON;
		endcase
	end

	// Next state of the stepper for one tick
	always_comb begin
		part_d   = part_q;
		active_d = active_q;
		frame_d  = frame_q;
		byte_d   = byte_q;
		bit_d    = bit_q;
		ph_d     = ph_q;
		shift_d  = shift_q;
		case (part_q)
			tw7s_pkg::PART_START: begin
				if (ph_q == 2'd0) begin
					ph_d = 2'd1;
				end else begin
					part_d  = tw7s_pkg::PART_BITS;
					bit_d   = 3'd0;
					ph_d    = 2'd0;
					shift_d = fb_byte;
				end
			end
			tw7s_pkg::PART_BITS: begin
				if (ph_q == 2'd0) begin
					ph_d = 2'd1;
				end else if (ph_q == 2'd1) begin
					ph_d = 2'd2;
				end else begin
					shift_d = shift_q >> 1;
					ph_d    = 2'd0;
					if (bit_q == tw7s_pkg::LAST_BIT) begin
						bit_d  = 3'd0;
						part_d = tw7s_pkg::PART_ACK;
					end else begin
						bit_d = bit_q + 3'd1;
					end
				end
			end
			tw7s_pkg::PART_ACK: begin
				if (ph_q == 2'd0) begin
					ph_d = 2'd1;
				end else if (ph_q == 2'd1) begin
					ph_d = 2'd2;
				end else begin
					ph_d = 2'd0;
					if (frame_q == tw7s_pkg::FRAME_ADDR && byte_q < tw7s_pkg::LAST_DIGIT) begin
						byte_d  = fb_idx;
						part_d  = tw7s_pkg::PART_BITS;
						bit_d   = 3'd0;
						shift_d = fb_byte;
					end else begin
						part_d = tw7s_pkg::PART_STOP;
					end
				end
			end
			default: begin
				if (ph_q != 2'd3) begin
					ph_d = ph_q + 2'd1;
				end else begin
					ph_d   = 2'd0;
					byte_d = 3'd0;
					part_d = tw7s_pkg::PART_START;
					if (frame_q != tw7s_pkg::FRAME_DISPON) begin
						frame_d = frame_q + 2'd1;
					end else begin
						frame_d  = tw7s_pkg::FRAME_DATA;
						active_d = 1'b0;
					end
				end
			end
		endcase
	end

	// Pin action for one tick: which pin of the target display and its level
	always_comb begin
		pin_is_data = 1'b0;
		pin_lvl     = 1'b0;
		case (part_q)
			tw7s_pkg::PART_START: begin
				pin_is_data = (ph_q == 2'd0);
			end
			tw7s_pkg::PART_BITS: begin
				pin_is_data = (ph_q == 2'd1);
				pin_lvl     = (ph_q == 2'd1) ? shift_q[0] : (ph_q != 2'd0);
			end
			tw7s_pkg::PART_ACK: begin
				pin_lvl = (ph_q == 2'd1);
			end
			default: begin
				pin_is_data = ph_q[0];
				pin_lvl     = ph_q[1];
			end
		endcase
		pins_d = pins_q;
		if (tick_go) begin
			pins_d[{tgt_q, pin_is_data}] = pin_lvl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q   <= tw7s_pkg::PART_START;
			pins_q   <= 4'hF;
			active_q <= 1'b0;
			tgt_q    <= 1'b0;
			frame_q  <= tw7s_pkg::FRAME_DATA;
			byte_q   <= 3'd0;
			bit_q    <= 3'd0;
			ph_q     <= 2'd0;
			shift_q  <= 8'h00;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (adv) begin
				m_tvalid <= 1'b1;
				if (show_go) begin
					// Latch a new time and arm the stepper; pins move on the first tick
					part_q   <= tw7s_pkg::PART_START;
					active_q <= 1'b1;
					tgt_q    <= disp_s1;
					frame_q  <= tw7s_pkg::FRAME_DATA;
					byte_q   <= 3'd0;
					bit_q    <= 3'd0;
					ph_q     <= 2'd0;
					shift_q  <= 8'h00;
				end else if (tick_go) begin
					part_q   <= part_d;
					pins_q   <= pins_d;
					active_q <= active_d;
					frame_q  <= frame_d;
					byte_q   <= byte_d;
					bit_q    <= bit_d;
					ph_q     <= ph_d;
					shift_q  <= shift_d;
				end
			end
		end
	end

	assign dig1 = tw7s_pkg::seg_pattern(tw7s_pkg::units_of(min_s1))
	            | (colon_s1 ? tw7s_pkg::COLON_BIT : 8'h00);

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {3'b000, tick_go ? active_d : (active_q || show_go), pins_d};
			if (show_go) begin
				digit_q[0] <= tw7s_pkg::seg_pattern(tw7s_pkg::tens_of(min_s1));
				digit_q[1] <= dig1;
				digit_q[2] <= tw7s_pkg::seg_pattern(tw7s_pkg::tens_of(sec_s1));
				digit_q[3] <= tw7s_pkg::seg_pattern(tw7s_pkg::units_of(sec_s1));
			end
		end
	end

	// Idle stepper always sits at the start of the first frame
	a_idle_home: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (part_q == tw7s_pkg::PART_START && frame_q == tw7s_pkg::FRAME_DATA
		               && byte_q == 3'd0))
		else $error("idle stepper not at start of first frame");

	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_q != 2'd3 && byte_q <= tw7s_pkg::LAST_DIGIT)
		else $error("frame or byte index out of range");

	a_bits_phase: assert property (@(posedge clk) disable iff (!arst_n)
		part_q != tw7s_pkg::PART_STOP |-> ph_q != 2'd3)
		else $error("phase beyond last step of section");

	a_other_pins_a: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && !tgt_q |=> pins_q[3:2] == $past(pins_q[3:2]))
		else $error("display B pins moved during display A transfer");

	a_other_pins_b: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && tgt_q |=> pins_q[1:0] == $past(pins_q[1:0]))
		else $error("display A pins moved during display B transfer");

endmodule

### tb/two_wire_seven_segment_time_driver_tb.sv
// Tracks pin levels and busy the way the two-wire stepper should, one accepted item at a time
class pin_level_checker;
	logic [3:0]  pins    = 4'hF;  // {data_b, clock_b, data_a, clock_a}
	logic        busy    = 1'b0;
	logic        target  = 1'b0;
	logic [7:0]  digits [4] = '{default: 8'h00};
	logic [1:0]  frame   = tw7s_pkg::FRAME_DATA;
	logic [2:0]  byte_no = 3'd0;
	logic [2:0]  bit_no  = 3'd0;
	logic [2:0]  phase   = 3'd0;
	logic [7:0]  shift   = 8'h00;
	tw7s_pkg::part_t part = tw7s_pkg::PART_START;
	logic [4:0]  levels_due [$];  // {busy, pins} per accepted item
	logic [7:0]  seg_lut [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
		8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
	string       field_names [5] = '{"clock_a", "data_a", "clock_b", "data_b", "busy_res"};
	int unsigned accepted, applied, refreshes, results, mismatches;

	function logic [7:0] seg_of(int unsigned d);
		return (d < 10) ? seg_lut[d] : 8'h00;
	endfunction

	function logic [7:0] frame_byte();
		case (frame)
		tw7s_pkg::FRAME_DATA: return tw7s_pkg::CMD_DATA;
		tw7s_pkg::FRAME_ADDR: return (byte_no == 3'd0) ? tw7s_pkg::CMD_ADDR
		                                               : digits[2'(byte_no - 3'd1)];
		default: return tw7s_pkg::CMD_DISPON;
		endcase
	endfunction

	// Only the selected display's pins move
	function void drive(logic is_data, logic level);
		pins[{target, is_data}] = level;
	endfunction

	function void load_byte();
		part   = tw7s_pkg::PART_BITS;
		bit_no = 3'd0;
		phase  = 3'd0;
		shift  = frame_byte();
	endfunction

	function void step();
		case (part)
		tw7s_pkg::PART_START: begin
			if (phase == 3'd0) begin
				drive(1'b1, 1'b0);
				phase = 3'd1;
			end else begin
				drive(1'b0, 1'b0);
				load_byte();
			end
		end
		tw7s_pkg::PART_BITS: begin
			if (phase == 3'd0) begin
				drive(1'b0, 1'b0);
				phase = 3'd1;
			end else if (phase == 3'd1) begin
				drive(1'b1, shift[0]);
				phase = 3'd2;
			end else begin
				drive(1'b0, 1'b1);
				shift = shift >> 1;
				phase = 3'd0;
				if (bit_no >= tw7s_pkg::LAST_BIT) begin
					bit_no = 3'd0;
					part   = tw7s_pkg::PART_ACK;
				end else begin
					bit_no = bit_no + 3'd1;
				end
			end
		end
		tw7s_pkg::PART_ACK: begin
			if (phase == 3'd0) begin
				drive(1'b0, 1'b0);
				phase = 3'd1;
			end else if (phase == 3'd1) begin
				drive(1'b0, 1'b1);
				phase = 3'd2;
			end else begin
				drive(1'b0, 1'b0);
				phase = 3'd0;
				if (frame == tw7s_pkg::FRAME_ADDR && byte_no < tw7s_pkg::LAST_DIGIT) begin
					byte_no = byte_no + 3'd1;
					load_byte();
				end else begin
					part = tw7s_pkg::PART_STOP;
				end
			end
		end
		default: begin
			if (phase == 3'd0) begin
				drive(1'b0, 1'b0);
				phase = 3'd1;
			end else if (phase == 3'd1) begin
				drive(1'b1, 1'b0);
				phase = 3'd2;
			end else if (phase == 3'd2) begin
				drive(1'b0, 1'b1);
				phase = 3'd3;
			end else begin
				drive(1'b1, 1'b1);
				phase   = 3'd0;
				byte_no = 3'd0;
				part    = tw7s_pkg::PART_START;
				if (frame < tw7s_pkg::FRAME_DISPON) begin
					frame = frame + 2'd1;
				end else begin
					frame = tw7s_pkg::FRAME_DATA;
					busy  = 1'b0;
					refreshes++;
				end
			end
		end
		endcase
	endfunction

	function void note_item(logic kind, logic sel, logic [6:0] mins, logic [6:0] secs,
			logic colon);
		int unsigned m;
		int unsigned s;
		m = mins;
		s = secs;
		accepted++;
		if (kind == tw7s_pkg::KIND_SHOW) begin
			if (!busy) begin
				target    = sel;
				digits[0] = seg_of(m / 10);
				digits[1] = seg_of(m % 10) | (colon ? tw7s_pkg::COLON_BIT : 8'h00);
				digits[2] = seg_of(s / 10);
				digits[3] = seg_of(s % 10);
				frame     = tw7s_pkg::FRAME_DATA;
				byte_no   = 3'd0;
				bit_no    = 3'd0;
				phase     = 3'd0;
				shift     = 8'h00;
				part      = tw7s_pkg::PART_START;
				busy      = 1'b1;
				applied++;
			end
		end else if (busy) begin
			step();
			applied++;
		end
		levels_due.push_back({busy, pins});
	endfunction

	task report(string msg);
		mismatches++;
		$display("MISMATCH %s", msg);
	endtask

	task check_pins(logic [7:0] word);
		logic [4:0] want;
		results++;
		if (levels_due.size() == 0) begin
			report($sformatf("result %0d arrived with nothing pending (%h)", results, word));
			return;
		end
		want = levels_due.pop_front();
		for (int i = 0; i < 5; i++)
			if (word[i] !== want[i])
				report($sformatf("result %0d: %s expected %b got %b",
					results, field_names[i], want[i], word[i]));
	endtask
endclass

module two_wire_seven_segment_time_driver_tb;
	localparam int          ITEMS       = 850;     // input items over the whole run
	localparam int          IDLE_PCT    = 26;      // chance in 100 that a side idles a cycle
	localparam int          HOLD_CYCLES = 80;      // long receiver hold-off
	localparam int unsigned CYCLE_LIMIT = 200000;  // watchdog

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// [0] display_select, [7:1] minutes, [14:8] seconds, [15] colon
	logic [15:0] s_tdata;
	// [0] kind
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// [0] clock_a, [1] data_a, [2] clock_b, [3] data_b, [4] busy_res, [7:5] zero
	logic [7:0]  m_tdata;

	pin_level_checker pin_check;
	logic        no_gaps  = 1'b0;  // set: neither side idles
	logic        hold_req = 1'b0;  // set by the stimulus, cleared by the receiver when done
	int unsigned cycle_count = 0;
	int unsigned base;
	int          hold_count;
	logic        kind;
	logic        held_once = 1'b0;
	logic        paused_once = 1'b0;

	two_wire_seven_segment_time_driver u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one item and hold it until the block takes the transfer, then let the
	// predictor see it. Returns on the edge of the transfer with s_tvalid still high,
	// so the caller's next drive is the only one in that time step.
	task automatic send_item(input logic k, input logic sel, input logic [6:0] mins,
			input logic [6:0] secs, input logic colon);
		while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {colon, secs, mins, sel};
		do @(posedge clk); while (!s_tready);
		pin_check.note_item(k, sel, mins, secs, colon);
	endtask

	// Step the pins until the write sequence has run all three frames
	task automatic tick_until_idle();
		while (pin_check.busy)
			send_item(tw7s_pkg::KIND_TICK, 1'($urandom_range(1)), 7'($urandom_range(127)),
				7'($urandom_range(127)), 1'($urandom_range(1)));
	endtask

	task automatic run_refresh(input logic sel, input logic [6:0] mins,
			input logic [6:0] secs, input logic colon);
		send_item(tw7s_pkg::KIND_SHOW, sel, mins, secs, colon);
		tick_until_idle();
	endtask

	// Drop valid and hold until every expected result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pin_check.levels_due.size() != 0);
	endtask

	// Mostly legal time values, some above 99 to hit blank digits
	function automatic logic [6:0] pick_time();
		return ($urandom_range(99) < 85) ? 7'($urandom_range(99)) : 7'($urandom_range(127, 100));
	endfunction

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		pin_check = new;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: tick while idle must leave the pins high
		send_item(tw7s_pkg::KIND_TICK, 1'b1, 7'd127, 7'd127, 1'b1);
		// Show 00:00 on A; a second show right behind it lands while busy and is dropped
		send_item(tw7s_pkg::KIND_SHOW, 1'b0, 7'd0, 7'd0, 1'b0);
		send_item(tw7s_pkg::KIND_SHOW, 1'b1, 7'd99, 7'd99, 1'b1);
		tick_until_idle();
		send_item(tw7s_pkg::KIND_TICK, 1'b0, 7'd0, 7'd0, 1'b0);
		// Minutes of 127 (blank tens, units 7), seconds of 100 (blank tens, zero units), colon lit, on display B
		run_refresh(1'b1, 7'd127, 7'd100, 1'b1);
		drain_results();

		// Random: mostly show-then-ticks sequences, with stray shows while busy and
		// stray ticks while idle as noise
		base = pin_check.accepted;
		while (pin_check.accepted < ITEMS) begin
			if (!held_once && pin_check.accepted - base >= 100) begin
				hold_req  = 1'b1;
				held_once = 1'b1;
			end
			if (!paused_once && pin_check.accepted - base >= 200) begin
				drain_results();
				paused_once = 1'b1;
			end
			no_gaps = (pin_check.accepted - base >= 250) && (pin_check.accepted - base < 380);
			if (pin_check.busy)
				kind = ($urandom_range(99) < 6) ? tw7s_pkg::KIND_SHOW : tw7s_pkg::KIND_TICK;
			else
				kind = ($urandom_range(99) < 15) ? tw7s_pkg::KIND_TICK : tw7s_pkg::KIND_SHOW;
			send_item(kind, 1'($urandom_range(1)), pick_time(), pick_time(),
				1'($urandom_range(1)));
		end
		no_gaps = 1'b0;

		drain_results();
		repeat (8) @(posedge clk);
		$display("covered %0d items (%0d changed state), %0d full write sequences on both displays",
			pin_check.accepted, pin_check.applied, pin_check.refreshes);
		$display("checked %0d results, %0d mismatches", pin_check.results, pin_check.mismatches);
		if (pin_check.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Receiver: random ready, one long hold-off on request so the pipe fills and
	// back-pressures the sender
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
					@(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Check every result transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			pin_check.check_pins(m_tdata);
	end

	// Watchdog: end the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycle_count, pin_check.levels_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule
